// File: sv/hpc_pkg.sv
package hpc_pkg;

  // input field widths
  localparam int MODE_W   = 2;
  localparam int BTN_W    = 8;
  localparam int WHEEL_W  = 8;
  localparam int ABS_W    = 16;
  localparam int DELTA_W  = 16;
  localparam int MOD_W    = 8;
  localparam int KEYS_W   = 48;

  // output field widths
  localparam int KIND_W   = 2;
  localparam int MOVE_W   = 8;
  localparam int PTR_W    = 15;

  // default burst bound of one relative flush
  localparam int MAX_SEGMENTS_DEF = 32;

  // per-report clamp of a relative step and of the wheel sum
  localparam int SEG_LIM = 127;

  // event kinds
  localparam logic [MODE_W-1:0] MODE_ABS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_KEY = 2'd2;

  // report kinds
  localparam logic [KIND_W-1:0] KIND_KEY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ABS = 2'd2;

  localparam logic signed [MOVE_W-1:0] MOVE_HI = 8'sd127;
  localparam logic signed [MOVE_W-1:0] MOVE_LO = -8'sd127;

endpackage

// File: sv/hid_pointer_coalescer.sv
// HID report coalescer. Keyboard, absolute-pointer and relative-mouse events come in one word
// at a time; runs of pointer events of one kind are merged into a held accumulation (latest
// buttons and coordinates, saturating wheel and delta sums) and flushed as reports when the
// event queue runs empty, when the pointer kind changes, or ahead of a keyboard report. A
// relative flush sends up to MAX_SEGMENTS step reports clamped to +-127 per axis, then a
// wheel-only report if the wheel is nonzero, or a bare report if nothing moved. Events seen
// while the host is not mounted are dropped together with any held accumulation. in_stall is
// high from the accepting edge until the event is fully worked off. All arithmetic runs through
// one saturating adder under a small sequencer, one operand per cycle while out_stall does not
// hold a report step. Merging an event runs from the accept through dispatch and the load step
// to the wheel, x and y sums as needed; a relative flush runs through the flush start, then x and
// y per step report, then the wheel report; an absolute flush and a keyboard report each end in their own report step.
// Every report waits in a single output register; while out_stall holds that register full, the
// report steps wait.
module hid_pointer_coalescer #(
  parameter int MAX_SEGMENTS = hpc_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,

  // event channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [hpc_pkg::MODE_W-1:0]          in_mode,
  input  logic [hpc_pkg::BTN_W-1:0]           in_buttons,
  input  logic signed [hpc_pkg::WHEEL_W-1:0]  in_wheel,
  input  logic [hpc_pkg::ABS_W-1:0]           in_abs_x,
  input  logic [hpc_pkg::ABS_W-1:0]           in_abs_y,
  input  logic signed [hpc_pkg::DELTA_W-1:0]  in_rel_dx,
  input  logic signed [hpc_pkg::DELTA_W-1:0]  in_rel_dy,
  input  logic [hpc_pkg::MOD_W-1:0]           in_key_modifier,
  input  logic [hpc_pkg::KEYS_W-1:0]          in_key_codes,
  input  logic                                in_queue_empty_after,
  input  logic                                in_host_mounted,

  // report channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hpc_pkg::KIND_W-1:0]          out_report_kind,
  output logic [hpc_pkg::BTN_W-1:0]           out_buttons,
  output logic signed [hpc_pkg::MOVE_W-1:0]   out_move_x,
  output logic signed [hpc_pkg::MOVE_W-1:0]   out_move_y,
  output logic signed [hpc_pkg::WHEEL_W-1:0]  out_wheel,
  output logic [hpc_pkg::PTR_W-1:0]           out_pointer_x,
  output logic [hpc_pkg::PTR_W-1:0]           out_pointer_y,
  output logic [hpc_pkg::MOD_W-1:0]           out_modifier,
  output logic [hpc_pkg::KEYS_W-1:0]          out_key_codes,
  output logic                                out_last
);

  import hpc_pkg::*;

  // saturation bound of the delta sums and the widths that follow from it
  localparam int SUM_LIMIT = SEG_LIM * MAX_SEGMENTS;
  localparam int SUM_W     = $clog2(SUM_LIMIT + 1) + 1;
  localparam int ALU_W     = ((SUM_W > DELTA_W) ? SUM_W : DELTA_W) + 1;

  localparam logic signed [SUM_W-1:0] SEG_HI   = SUM_W'(SEG_LIM);
  localparam logic signed [SUM_W-1:0] SEG_LO   = -SEG_HI;
  localparam logic signed [ALU_W-1:0] LIM_SUM  = ALU_W'(SUM_LIMIT);
  localparam logic signed [ALU_W-1:0] LIM_WHL  = ALU_W'(SEG_LIM);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ACC,
    S_ACC_W,
    S_ACC_X,
    S_ACC_Y,
    S_FLUSH,
    S_FLR_X,
    S_FLR_Y,
    S_FLR_W,
    S_FLA,
    S_KEY
  } state_t;

  // what follows a flush
  typedef enum logic [1:0] {
    RET_DONE,
    RET_ACC,
    RET_KEY
  } ret_t;

  state_t state_r, state_nxt;
  ret_t   ret_r, ret_nxt;

  // captured event word
  logic [MODE_W-1:0]          ev_mode_r, ev_mode_nxt;
  logic [BTN_W-1:0]           ev_buttons_r, ev_buttons_nxt;
  logic signed [WHEEL_W-1:0]  ev_wheel_r, ev_wheel_nxt;
  logic [ABS_W-1:0]           ev_abs_x_r, ev_abs_x_nxt;
  logic [ABS_W-1:0]           ev_abs_y_r, ev_abs_y_nxt;
  logic signed [DELTA_W-1:0]  ev_dx_r, ev_dx_nxt;
  logic signed [DELTA_W-1:0]  ev_dy_r, ev_dy_nxt;
  logic [MOD_W-1:0]           ev_mod_r, ev_mod_nxt;
  logic [KEYS_W-1:0]          ev_keys_r, ev_keys_nxt;
  logic                       ev_qempty_r, ev_qempty_nxt;
  logic                       ev_mounted_r, ev_mounted_nxt;

  // held accumulation
  logic                       held_valid_r, held_valid_nxt;
  logic                       held_rel_r, held_rel_nxt;
  logic [BTN_W-1:0]           held_buttons_r, held_buttons_nxt;
  logic signed [WHEEL_W-1:0]  held_wheel_r, held_wheel_nxt;
  logic [ABS_W-1:0]           held_abs_x_r, held_abs_x_nxt;
  logic [ABS_W-1:0]           held_abs_y_r, held_abs_y_nxt;
  logic signed [SUM_W-1:0]    sum_dx_r, sum_dx_nxt;
  logic signed [SUM_W-1:0]    sum_dy_r, sum_dy_nxt;
  logic signed [MOVE_W-1:0]   seg_x_r, seg_x_nxt;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]          out_kind_r, out_kind_nxt;
  logic [BTN_W-1:0]           out_buttons_r, out_buttons_nxt;
  logic signed [MOVE_W-1:0]   out_move_x_r, out_move_x_nxt;
  logic signed [MOVE_W-1:0]   out_move_y_r, out_move_y_nxt;
  logic signed [WHEEL_W-1:0]  out_wheel_r, out_wheel_nxt;
  logic [PTR_W-1:0]           out_px_r, out_px_nxt;
  logic [PTR_W-1:0]           out_py_r, out_py_nxt;
  logic [MOD_W-1:0]           out_mod_r, out_mod_nxt;
  logic [KEYS_W-1:0]          out_keys_r, out_keys_nxt;
  logic                       out_last_r, out_last_nxt;

  // shared saturating adder
  logic signed [ALU_W-1:0]    alu_a, alu_b, alu_lim, alu_sum, alu_res;

  // per-axis step clamp, shared by both axes of the segment loop
  logic signed [SUM_W-1:0]    axis;
  logic signed [MOVE_W-1:0]   seg_step;

  logic                       out_free;
  logic                       ev_rel;
  logic                       flush_last;
  logic                       flush_done;
  logic                       acc_done;
  logic [PTR_W-1:0]           clamp_px, clamp_py;

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign ev_rel   = (ev_mode_r == MODE_REL);

  // last report of a flush ends the event unless a key report follows, or a load follows that
  // is followed by a queue-empty flush; that flush always emits again
  assign flush_last = (ret_r == RET_DONE) || ((ret_r == RET_ACC) && !ev_qempty_r);

  assign clamp_px = held_abs_x_r[ABS_W-1] ? '1 : held_abs_x_r[PTR_W-1:0];
  assign clamp_py = held_abs_y_r[ABS_W-1] ? '1 : held_abs_y_r[PTR_W-1:0];

  assign axis = (state_r == S_FLR_Y) ? sum_dy_r : sum_dx_r;
  assign seg_step = (axis > SEG_HI) ? MOVE_HI :
                    (axis < SEG_LO) ? MOVE_LO : axis[MOVE_W-1:0];

  // operand selection for the adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_lim = LIM_SUM;
    case (state_r)
      S_ACC_W: begin
        alu_a   = ALU_W'(held_wheel_r);
        alu_b   = ALU_W'(ev_wheel_r);
        alu_lim = LIM_WHL;
      end
      S_ACC_X: begin
        alu_a = ALU_W'(sum_dx_r);
        alu_b = ALU_W'(ev_dx_r);
      end
      S_ACC_Y: begin
        alu_a = ALU_W'(sum_dy_r);
        alu_b = ALU_W'(ev_dy_r);
      end
      S_FLR_X, S_FLR_Y: begin
        // take one clamped step off the axis
        alu_a = ALU_W'(axis);
        alu_b = -(ALU_W'(seg_step));
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_sum = alu_a + alu_b;
  assign alu_res = (alu_sum > alu_lim)  ? alu_lim :
                   (alu_sum < -alu_lim) ? -alu_lim : alu_sum;

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    ret_nxt          = ret_r;
    ev_mode_nxt      = ev_mode_r;
    ev_buttons_nxt   = ev_buttons_r;
    ev_wheel_nxt     = ev_wheel_r;
    ev_abs_x_nxt     = ev_abs_x_r;
    ev_abs_y_nxt     = ev_abs_y_r;
    ev_dx_nxt        = ev_dx_r;
    ev_dy_nxt        = ev_dy_r;
    ev_mod_nxt       = ev_mod_r;
    ev_keys_nxt      = ev_keys_r;
    ev_qempty_nxt    = ev_qempty_r;
    ev_mounted_nxt   = ev_mounted_r;
    held_valid_nxt   = held_valid_r;
    held_rel_nxt     = held_rel_r;
    held_buttons_nxt = held_buttons_r;
    held_wheel_nxt   = held_wheel_r;
    held_abs_x_nxt   = held_abs_x_r;
    held_abs_y_nxt   = held_abs_y_r;
    sum_dx_nxt       = sum_dx_r;
    sum_dy_nxt       = sum_dy_r;
    seg_x_nxt        = seg_x_r;

    out_valid_nxt    = out_valid_r && out_stall;
    out_kind_nxt     = out_kind_r;
    out_buttons_nxt  = out_buttons_r;
    out_move_x_nxt   = out_move_x_r;
    out_move_y_nxt   = out_move_y_r;
    out_wheel_nxt    = out_wheel_r;
    out_px_nxt       = out_px_r;
    out_py_nxt       = out_py_r;
    out_mod_nxt      = out_mod_r;
    out_keys_nxt     = out_keys_r;
    out_last_nxt     = out_last_r;

    flush_done = 1'b0;
    acc_done   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ev_mode_nxt    = in_mode;
          ev_buttons_nxt = in_buttons;
          ev_wheel_nxt   = in_wheel;
          ev_abs_x_nxt   = in_abs_x;
          ev_abs_y_nxt   = in_abs_y;
          ev_dx_nxt      = in_rel_dx;
          ev_dy_nxt      = in_rel_dy;
          ev_mod_nxt     = in_key_modifier;
          ev_keys_nxt    = in_key_codes;
          ev_qempty_nxt  = in_queue_empty_after;
          ev_mounted_nxt = in_host_mounted;
          state_nxt      = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        if (!ev_mounted_r) begin
          // unmounted host: drop the word and anything held
          held_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end else begin
          case (ev_mode_r)
            MODE_KEY: begin
              if (held_valid_r) begin
                ret_nxt   = RET_KEY;
                state_nxt = S_FLUSH;
              end else begin
                state_nxt = S_KEY;
              end
            end
            MODE_ABS, MODE_REL: begin
              if (held_valid_r && (held_rel_r != ev_rel)) begin
                ret_nxt   = RET_ACC;
                state_nxt = S_FLUSH;
              end else begin
                state_nxt = S_ACC;
              end
            end
            default: begin
              // unused kind: ignored, state untouched
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_ACC: begin
        held_buttons_nxt = ev_buttons_r;
        if (!held_valid_r || !ev_rel) begin
          held_abs_x_nxt = ev_abs_x_r;
          held_abs_y_nxt = ev_abs_y_r;
        end
        if (!held_valid_r) begin
          // fresh load: wheel taken raw, deltas go through the saturating adder
          held_valid_nxt = 1'b1;
          held_rel_nxt   = ev_rel;
          held_wheel_nxt = ev_wheel_r;
          sum_dx_nxt     = '0;
          sum_dy_nxt     = '0;
          if (ev_rel) begin
            state_nxt = S_ACC_X;
          end else begin
            acc_done = 1'b1;
          end
        end else begin
          state_nxt = S_ACC_W;
        end
      end

      S_ACC_W: begin
        held_wheel_nxt = alu_res[WHEEL_W-1:0];
        if (held_rel_r) begin
          state_nxt = S_ACC_X;
        end else begin
          acc_done = 1'b1;
        end
      end

      S_ACC_X: begin
        sum_dx_nxt = alu_res[SUM_W-1:0];
        state_nxt  = S_ACC_Y;
      end

      S_ACC_Y: begin
        sum_dy_nxt = alu_res[SUM_W-1:0];
        acc_done   = 1'b1;
      end

      S_FLUSH: begin
        state_nxt = held_rel_r ? S_FLR_X : S_FLA;
      end

      S_FLR_X: begin
        if ((sum_dx_r == '0) && (sum_dy_r == '0)) begin
          // no motion at all: wheel-only or bare report
          state_nxt = S_FLR_W;
        end else begin
          seg_x_nxt  = seg_step;
          sum_dx_nxt = alu_res[SUM_W-1:0];
          state_nxt  = S_FLR_Y;
        end
      end

      S_FLR_Y: begin
        if (out_free) begin
          sum_dy_nxt      = alu_res[SUM_W-1:0];
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_REL;
          out_buttons_nxt = held_buttons_r;
          out_move_x_nxt  = seg_x_r;
          out_move_y_nxt  = seg_step;
          out_wheel_nxt   = '0;
          out_px_nxt      = '0;
          out_py_nxt      = '0;
          out_mod_nxt     = '0;
          out_keys_nxt    = '0;
          out_last_nxt    = (sum_dx_r == '0) && (alu_res == '0) &&
                            (held_wheel_r == '0) && flush_last;
          if ((sum_dx_r != '0) || (alu_res != '0)) begin
            state_nxt = S_FLR_X;
          end else if (held_wheel_r != '0) begin
            state_nxt = S_FLR_W;
          end else begin
            flush_done = 1'b1;
          end
        end
      end

      S_FLR_W: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_REL;
          out_buttons_nxt = held_buttons_r;
          out_move_x_nxt  = '0;
          out_move_y_nxt  = '0;
          out_wheel_nxt   = held_wheel_r;
          out_px_nxt      = '0;
          out_py_nxt      = '0;
          out_mod_nxt     = '0;
          out_keys_nxt    = '0;
          out_last_nxt    = flush_last;
          flush_done      = 1'b1;
        end
      end

      S_FLA: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_ABS;
          out_buttons_nxt = held_buttons_r;
          out_move_x_nxt  = '0;
          out_move_y_nxt  = '0;
          out_wheel_nxt   = held_wheel_r;
          out_px_nxt      = clamp_px;
          out_py_nxt      = clamp_py;
          out_mod_nxt     = '0;
          out_keys_nxt    = '0;
          out_last_nxt    = flush_last;
          flush_done      = 1'b1;
        end
      end

      S_KEY: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_KEY;
          out_buttons_nxt = '0;
          out_move_x_nxt  = '0;
          out_move_y_nxt  = '0;
          out_wheel_nxt   = '0;
          out_px_nxt      = '0;
          out_py_nxt      = '0;
          out_mod_nxt     = ev_mod_r;
          out_keys_nxt    = ev_keys_r;
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // accumulation finished: flush now if the queue ran empty
    if (acc_done) begin
      ret_nxt   = RET_DONE;
      state_nxt = ev_qempty_r ? S_FLUSH : S_IDLE;
    end

    if (flush_done) begin
      held_valid_nxt = 1'b0;
      case (ret_r)
        RET_KEY: state_nxt = S_KEY;
        RET_ACC: state_nxt = S_ACC;
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_r        <= RET_DONE;
      held_valid_r <= 1'b0;
      held_rel_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ret_r        <= ret_nxt;
      held_valid_r <= held_valid_nxt;
      held_rel_r   <= held_rel_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    ev_mode_r      <= ev_mode_nxt;
    ev_buttons_r   <= ev_buttons_nxt;
    ev_wheel_r     <= ev_wheel_nxt;
    ev_abs_x_r     <= ev_abs_x_nxt;
    ev_abs_y_r     <= ev_abs_y_nxt;
    ev_dx_r        <= ev_dx_nxt;
    ev_dy_r        <= ev_dy_nxt;
    ev_mod_r       <= ev_mod_nxt;
    ev_keys_r      <= ev_keys_nxt;
    ev_qempty_r    <= ev_qempty_nxt;
    ev_mounted_r   <= ev_mounted_nxt;
    held_buttons_r <= held_buttons_nxt;
    held_wheel_r   <= held_wheel_nxt;
    held_abs_x_r   <= held_abs_x_nxt;
    held_abs_y_r   <= held_abs_y_nxt;
    sum_dx_r       <= sum_dx_nxt;
    sum_dy_r       <= sum_dy_nxt;
    seg_x_r        <= seg_x_nxt;
    out_kind_r     <= out_kind_nxt;
    out_buttons_r  <= out_buttons_nxt;
    out_move_x_r   <= out_move_x_nxt;
    out_move_y_r   <= out_move_y_nxt;
    out_wheel_r    <= out_wheel_nxt;
    out_px_r       <= out_px_nxt;
    out_py_r       <= out_py_nxt;
    out_mod_r      <= out_mod_nxt;
    out_keys_r     <= out_keys_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_report_kind = out_kind_r;
  assign out_buttons     = out_buttons_r;
  assign out_move_x      = out_move_x_r;
  assign out_move_y      = out_move_y_r;
  assign out_wheel       = out_wheel_r;
  assign out_pointer_x   = out_px_r;
  assign out_pointer_y   = out_py_r;
  assign out_modifier    = out_mod_r;
  assign out_key_codes   = out_keys_r;
  assign out_last        = out_last_r;

endmodule
